// ===== rtl/core/rhs_pkg.sv =====
package rhs_pkg;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 5;
    localparam int PCHARS_W  = 64;
    localparam int HASH_W    = 27;
    localparam int POS_W     = 48;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PK_W      = 4;    // index into the pattern and power tables
    localparam int POW3_W    = 24;   // 3^15 fits in 24 bits

    // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for every x below 2^29
    localparam int DIV3_W     = 28;
    localparam int DIV3_SHIFT = 29;
    localparam logic [DIV3_W-1:0] DIV3_MUL = 28'd178956971;

    typedef enum logic [KIND_W-1:0] {
        K_HASH    = 2'd0,
        K_POS     = 2'd1,
        K_NOMATCH = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEN = 2'd0,
        CFG_LO  = 2'd1,
        CFG_HI  = 2'd2
    } t_cfg_idx;

    // operands of the shared term unit: a + d3 * 3^k
    typedef struct packed {
        logic [HASH_W-1:0] a;
        logic [1:0]        d3;
        logic [PK_W-1:0]   k;
    } t_term_req;

    function automatic logic [1:0] f_mod3(input logic [CHAR_W-1:0] b);
        logic [3:0] s;
        logic [2:0] t;
        logic [1:0] r;
        // 4 = 1 (mod 3): fold base-4 digits twice
        s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        case (t)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4:       r = 2'd1;
            3'd2, 3'd5:       r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [POW3_W-1:0] f_pow3(input logic [PK_W-1:0] k);
        logic [POW3_W-1:0] p;
        case (k)
            4'd0:    p = 24'd1;
            4'd1:    p = 24'd3;
            4'd2:    p = 24'd9;
            4'd3:    p = 24'd27;
            4'd4:    p = 24'd81;
            4'd5:    p = 24'd243;
            4'd6:    p = 24'd729;
            4'd7:    p = 24'd2187;
            4'd8:    p = 24'd6561;
            4'd9:    p = 24'd19683;
            4'd10:   p = 24'd59049;
            4'd11:   p = 24'd177147;
            4'd12:   p = 24'd531441;
            4'd13:   p = 24'd1594323;
            4'd14:   p = 24'd4782969;
            4'd15:   p = 24'd14348907;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

    function automatic logic [CHAR_W-1:0] f_pchar(input logic [PCHARS_W-1:0] lo,
                                                  input logic [PCHARS_W-1:0] hi,
                                                  input logic [PK_W-1:0]     k);
        logic [PCHARS_W-1:0] w;
        w = k[3] ? hi : lo;
        return w[{k[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

// ===== rtl/core/rhs_if.sv =====
interface rhs_in_if;
    import rhs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] data_byte;
    logic              end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rhs_out_if;
    import rhs_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [POS_W-1:0]  result_value;
    logic              last_of_run;

    modport source (output valid, output result_kind, output result_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input result_value,
                    input last_of_run, output ready);
endinterface

interface rhs_cfg_if;
    import rhs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PCHARS_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rolling_hash_substring_search.sv =====
// Rolling-hash substring search over a byte stream. Each input word carries one text
// byte (or an end-of-stream flag); the block keeps the last N bytes (N = pattern_length,
// clamped to 1..MAX_PATTERN) and a hash sum((byte mod 3) * 3^k) over them, oldest at
// k = 0. When a full window hashes to the pattern's hash, it emits the hash (first hit
// only), then one word per compared character carrying its 1-based text position,
// stopping after the first mismatch or the last character. An end-of-stream word yields
// a single no-match word until a hit has occurred. A text byte passes through accept,
// divide by 3, hash update and hit check, all through one shared a + d*3^k term adder
// and a reciprocal multiplier. The first byte after a pattern or length write first
// waits while the same adder rebuilds the pattern hash one character a cycle. On a
// hit the position words follow the hit check (the hash word leaves during the hit
// check), held back by any output back-pressure. The window is a small memory with one
// registered read port and a valid bit per entry, so no clearing pass follows reset.
// Configuration is accepted only while the block is idle and takes priority over a text
// word offered in the same cycle; write it only while nothing is in flight.
module rolling_hash_substring_search import rhs_pkg::*; #(
    parameter int MAX_PATTERN = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhs_cfg_if.sink    i_cfg,
    rhs_in_if.sink     i_in,
    rhs_out_if.source  o_out
);

    localparam int NW  = $clog2(MAX_PATTERN + 1);
    localparam int KW  = $clog2(MAX_PATTERN);
    localparam int PW1 = POS_W + 1;
    localparam int PRW = HASH_W + DIV3_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PH,
        S_DIV,
        S_UPD,
        S_HIT,
        S_CMP,
        S_EOS
    } t_state;

    t_state r_state;

    // configuration
    logic [LEN_W-1:0]    r_len;
    logic [PCHARS_W-1:0] r_plo;
    logic [PCHARS_W-1:0] r_phi;
    logic                r_ph_ok;
    logic [HASH_W-1:0]   r_phash;

    // window memory
    logic [CHAR_W-1:0]      r_mem [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_valid;
    logic [CHAR_W-1:0]      r_rd;
    logic                   r_rd_vld;
    logic                   rd_en;
    logic [KW-1:0]          rd_addr;

    // stream state
    logic [KW-1:0]     r_head;
    logic [POS_W-1:0]  r_seen;
    logic [HASH_W-1:0] r_hash;
    logic              r_any;

    // per-word working registers
    logic [CHAR_W-1:0] r_c;
    logic [1:0]        r_c3;
    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] r_quot;
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_ptr;
    logic [PW1-1:0]    r_pos;
    logic              r_full;

    // output register
    logic              r_ov;
    t_kind             r_okind;
    logic [POS_W-1:0]  r_oval;
    logic              r_olast;

    logic [NW-1:0]     n;
    logic [KW-1:0]     head_clamp;
    logic [KW-1:0]     head_next;
    logic [KW-1:0]     ptr_next;
    logic              in_fire;
    logic              cfg_fire;
    logic              slot_free;
    logic [CHAR_W-1:0] rd_data;
    logic              mismatch;
    logic              k_last;
    logic              below_n;
    logic              hit;
    logic [HASH_W-1:0] h_sub;
    logic [PRW-1:0]    prod;
    logic [HASH_W-1:0] quot;
    logic [POS_W-1:0]  pos_sat;
    logic              emit_hash;
    logic              emit_pos;
    logic              emit_eos;
    logic              emit;
    t_kind             n_okind;
    logic [POS_W-1:0]  n_oval;
    logic              n_olast;
    t_term_req         term_req;
    logic [HASH_W-1:0] term_sum;

    // length in use: zero acts as one, anything above the window as the window
    always_comb begin
        if (r_len == '0) begin
            n = NW'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            n = NW'(MAX_PATTERN);
        end else begin
            n = NW'(r_len);
        end
    end

    assign in_fire   = i_in.valid && i_in.ready;
    assign cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign slot_free = !r_ov || o_out.ready;

    // hold text back while a register write is offered
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);

    // a length shrink can leave the head beyond the window: restart it at 0
    assign head_clamp = (6'(r_head) >= 6'(n)) ? '0 : r_head;
    assign head_next  = (6'(r_head) + 6'd1 == 6'(n)) ? '0 : r_head + KW'(1);
    assign ptr_next   = (6'(r_ptr) + 6'd1 == 6'(n)) ? '0 : r_ptr + KW'(1);

    // entries never written read as zero
    assign rd_data  = r_rd_vld ? r_rd : '0;
    assign mismatch = (rd_data != f_pchar(r_plo, r_phi, PK_W'(r_k)));
    assign k_last   = (6'(r_k) + 6'd1 == 6'(n));
    assign below_n  = (r_seen < POS_W'(n));
    assign hit      = r_full && (r_hash == r_phash);
    assign pos_sat  = r_pos[POS_W] ? '1 : r_pos[POS_W-1:0];

    // drop the oldest byte's digit, then divide by 3 with a reciprocal multiply
    assign h_sub = r_hash - HASH_W'(f_mod3(rd_data));
    assign prod  = PRW'(h_sub) * PRW'(DIV3_MUL);
    assign quot  = HASH_W'(prod >> DIV3_SHIFT);

    // shared term adder: pattern hash build, growing-window add, sliding-window add
    always_comb begin
        term_req.a  = r_acc;
        term_req.d3 = f_mod3(f_pchar(r_plo, r_phi, PK_W'(r_k)));
        term_req.k  = PK_W'(r_k);
        if (r_state == S_UPD) begin
            term_req.d3 = r_c3;
            if (below_n) begin
                term_req.a = r_hash;
                term_req.k = r_seen[PK_W-1:0];
            end else begin
                term_req.a = r_quot;
                term_req.k = PK_W'(n - NW'(1));
            end
        end
    end

    rhs_term_unit u_term (
        .i_req (term_req),
        .o_sum (term_sum)
    );

    // window read port: old byte at accept, then one compared byte per word
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ptr;
        case (r_state)
            S_IDLE: begin
                rd_en   = in_fire && !i_in.end_of_stream;
                rd_addr = head_clamp;
            end
            S_HIT: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
            end
            S_CMP: begin
                rd_en   = slot_free;
                rd_addr = ptr_next;
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_ptr;
            end
        endcase
    end

    assign emit_hash = (r_state == S_HIT) && hit && !r_any && slot_free;
    assign emit_pos  = (r_state == S_CMP) && slot_free;
    assign emit_eos  = (r_state == S_EOS) && slot_free;
    assign emit      = emit_hash || emit_pos || emit_eos;

    always_comb begin
        n_okind = K_NOMATCH;
        n_oval  = '0;
        n_olast = 1'b1;
        if (emit_hash) begin
            n_okind = K_HASH;
            n_oval  = POS_W'(r_hash);
            n_olast = 1'b0;
        end else if (emit_pos) begin
            n_okind = K_POS;
            n_oval  = pos_sat;
            n_olast = mismatch || k_last;
        end
    end

    // control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= LEN_W'(1);
            r_plo   <= '0;
            r_phi   <= '0;
            r_ph_ok <= 1'b0;
            r_valid <= '0;
            r_head  <= '0;
            r_seen  <= '0;
            r_hash  <= '0;
            r_any   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_LEN: begin
                        r_len   <= i_cfg.data[LEN_W-1:0];
                        r_ph_ok <= 1'b0;
                    end
                    CFG_LO: begin
                        r_plo   <= i_cfg.data;
                        r_ph_ok <= 1'b0;
                    end
                    CFG_HI: begin
                        r_phi   <= i_cfg.data;
                        r_ph_ok <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in.end_of_stream) begin
                            if (!r_any) begin
                                r_state <= S_EOS;
                            end
                        end else begin
                            r_head  <= head_clamp;
                            r_state <= r_ph_ok ? S_DIV : S_PH;
                        end
                    end
                end
                S_PH: begin
                    if (k_last) begin
                        r_ph_ok <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_hash          <= term_sum;
                    r_valid[r_head] <= 1'b1;
                    r_head          <= head_next;
                    if (r_seen != '1) begin
                        r_seen <= r_seen + POS_W'(1);
                    end
                    r_state <= S_HIT;
                end
                S_HIT: begin
                    if (!hit) begin
                        r_state <= S_IDLE;
                    end else if (r_any || slot_free) begin
                        r_any   <= 1'b1;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (slot_free && (mismatch || k_last)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EOS: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // working registers and output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_okind <= n_okind;
            r_oval  <= n_oval;
            r_olast <= n_olast;
        end
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_c   <= i_in.data_byte;
                    r_c3  <= f_mod3(i_in.data_byte);
                    r_acc <= '0;
                    r_k   <= '0;
                end
            end
            S_PH: begin
                r_acc <= term_sum;
                r_k   <= r_k + KW'(1);
                if (k_last) begin
                    r_phash <= term_sum;
                end
            end
            S_DIV: begin
                r_quot <= quot;
            end
            S_UPD: begin
                r_full <= (PW1'(r_seen) + PW1'(1)) >= PW1'(n);
                r_pos  <= PW1'(r_seen) + PW1'(2) - PW1'(n);
            end
            S_HIT: begin
                r_k   <= '0;
                r_ptr <= r_head;
            end
            S_CMP: begin
                if (slot_free) begin
                    r_k   <= r_k + KW'(1);
                    r_pos <= r_pos + PW1'(1);
                    r_ptr <= ptr_next;
                end
            end
            default: begin
            end
        endcase
    end

    // window memory: write the new byte, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_mem[r_head] <= r_c;
        end
        if (rd_en) begin
            r_rd     <= r_mem[rd_addr];
            r_rd_vld <= r_valid[rd_addr];
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.result_kind  = r_okind;
    assign o_out.result_value = r_oval;
    assign o_out.last_of_run  = r_olast;

    // a no-match word always closes its run
    a_nomatch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_okind == K_NOMATCH)) |-> r_olast)
        else $error("no-match word without last_of_run");

    // a hash word is always followed by at least one position word
    a_hash_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_okind == K_HASH)) |-> !r_olast)
        else $error("hash word marked last_of_run");

    // the first hash word latches the hit flag
    a_hash_marks_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_hash |=> r_any)
        else $error("hit flag not set after hash word");

    // after an update the head sits inside the window
    a_head_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HIT) |-> (6'(r_head) < 6'(n)))
        else $error("window head outside the window");

endmodule

// ===== rtl/core/rhs_term_unit.sv =====
module rhs_term_unit import rhs_pkg::*; (
    input  t_term_req         i_req,
    output logic [HASH_W-1:0] o_sum
);

    logic [POW3_W-1:0] pow;
    logic [POW3_W:0]   term;

    // d3 is a residue mod 3, so the product is a shift and select
    always_comb begin
        pow = f_pow3(i_req.k);
        case (i_req.d3)
            2'd1:    term = {1'b0, pow};
            2'd2:    term = {pow, 1'b0};
            default: term = '0;
        endcase
    end

    assign o_sum = i_req.a + HASH_W'(term);

endmodule
